// File: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL. Define NO_ASSERTIONS to
// compile them out.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`else

`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// File: hdl/elmxh_pkg.sv
// ---------------------------------------------------------------------------
// elmxh_pkg
// Types, constants and tables of the eight-lane multiply-xor hash unit.
// ---------------------------------------------------------------------------
`default_nettype none

package elmxh_pkg;

   // default number of length bits that take part in the hash
   localparam int LENGTH_BITS_DEF = 32;

   // packed request payload: msg_length, seed, data_word
   localparam int MSG_LENGTH_W = 32;
   localparam int REQ_TDATA_W  = 160;
   localparam int RSP_TDATA_W  = 64;

   // request kinds carried in tuser
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_DATA  = 1'b1;

   localparam int LANES = 8;
   localparam logic [2:0] LANE_LAST = 3'd7;
   localparam logic [2:0] RED_LAST  = 3'd6;
   localparam logic [2:0] FIN_LAST  = 3'd2;

   localparam logic [63:0] PHI  = 64'h9E3779B97F4A7C15;
   localparam logic [63:0] MUL1 = 64'h85EBCA77C2B2AE3D;
   localparam logic [63:0] MUL2 = 64'hBF58476D1CE4E5B9;
   localparam logic [63:0] MUL3 = 64'h94D049BB133111EB;

   // datapath operation being sequenced
   typedef enum logic [2:0] {
      OP_BASE,
      OP_SEED,
      OP_ABSORB,
      OP_REDUCE,
      OP_FINAL
   } op_type;

   // partial-product pass of the 64x64 low-half multiply
   typedef enum logic [1:0] {
      PH_LL,
      PH_LH,
      PH_HL
   } phase_type;

   typedef struct packed {
      logic      start;
      logic      absorb;
      logic      load;
      logic      mul_en;
      phase_type phase;
      op_type    op;
      logic [2:0] idx;
      logic      emit;
   } dp_cmd_type;

   typedef struct packed {
      logic len_zero;
      logic last_word;
      logic rsp_free;
   } dp_stat_type;

   // per-lane seeding multiplier
   function automatic logic [63:0] seed_mul(input logic [2:0] lane);
      logic [63:0] m;
      unique case (lane)
         3'd0: m = PHI;
         3'd1: m = MUL1;
         3'd2: m = MUL2;
         3'd3: m = MUL3;
         3'd4: m = 64'hA3C8B9D5E1F2A7B4;
         3'd5: m = 64'hC6A4A7935BD1E995;
         3'd6: m = 64'h9C3B7A5D1E8F6B2A;
         default: m = 64'hD4E5F6A7B8C9D0E1;
      endcase
      return m;
   endfunction

   // per-lane rotation of absorbed words
   function automatic logic [5:0] lane_rot(input logic [2:0] lane);
      logic [5:0] r;
      unique case (lane)
         3'd0: r = 6'd11;
         3'd1: r = 6'd15;
         3'd2: r = 6'd19;
         3'd3: r = 6'd23;
         3'd4: r = 6'd27;
         3'd5: r = 6'd31;
         3'd6: r = 6'd35;
         default: r = 6'd47;
      endcase
      return r;
   endfunction

   function automatic logic [63:0] rotl64(input logic [63:0] v, input logic [5:0] r);
      return (v << r) | (v >> (6'd0 - r));
   endfunction

   // finalizer xorshift amounts and multipliers
   function automatic logic [5:0] fin_shift(input logic [2:0] step);
      logic [5:0] s;
      unique case (step)
         3'd0: s = 6'd29;
         3'd1: s = 6'd31;
         default: s = 6'd37;
      endcase
      return s;
   endfunction

   function automatic logic [63:0] fin_mul(input logic [2:0] step);
      logic [63:0] m;
      unique case (step)
         3'd0: m = MUL1;
         3'd1: m = MUL2;
         default: m = PHI;
      endcase
      return m;
   endfunction

   // lane that receives each tree merge (the last merge goes to h)
   function automatic logic [2:0] red_dest(input logic [2:0] step);
      logic [2:0] d;
      unique case (step)
         3'd0: d = 3'd0;
         3'd1: d = 3'd2;
         3'd2: d = 3'd4;
         3'd3: d = 3'd6;
         3'd4: d = 3'd0;
         default: d = 3'd4;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

// File: hdl/elmxh_ctrl.sv
// ---------------------------------------------------------------------------
// elmxh_ctrl
// Sequencer: accepts items and steps the datapath through seeding,
// absorbing, tree reduction, finalization and result hand-off.
// ---------------------------------------------------------------------------
`default_nettype none

module elmxh_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic                  req_cmd,
   input  wire elmxh_pkg::dp_stat_type stat,
   output elmxh_pkg::dp_cmd_type      cmd
);
   import elmxh_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL,
      ST_EMIT
   } state_type;

   state_type state_ff;
   op_type    op_ff;
   phase_type phase_ff;
   logic [2:0] idx_ff;
   logic      open_ff;
   logic      fin_ff;
   logic      accept;

   // item handshake and commands
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cmd.start  = accept && (req_cmd == CMD_START);
      cmd.absorb = accept && (req_cmd == CMD_DATA) && open_ff;
      cmd.load   = (state_ff == ST_LOAD);
      cmd.mul_en = (state_ff == ST_MUL);
      cmd.phase  = phase_ff;
      cmd.op     = op_ff;
      cmd.idx    = idx_ff;
      cmd.emit   = (state_ff == ST_EMIT) && stat.rsp_free;
   end

   // state machine
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_BASE;
         phase_ff <= PH_LL;
         idx_ff   <= 3'd0;
         open_ff  <= 1'b0;
         fin_ff   <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               phase_ff <= PH_LL;
               if (cmd.start) begin
                  op_ff    <= OP_BASE;
                  idx_ff   <= 3'd0;
                  state_ff <= ST_MUL;
                  open_ff  <= !stat.len_zero;
                  fin_ff   <= stat.len_zero;
               end else if (cmd.absorb) begin
                  op_ff    <= OP_ABSORB;
                  state_ff <= ST_MUL;
                  fin_ff   <= stat.last_word;
                  if (stat.last_word) begin
                     open_ff <= 1'b0;
                  end
               end
            end
            ST_LOAD: begin
               phase_ff <= PH_LL;
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               unique case (phase_ff)
                  PH_LL: phase_ff <= PH_LH;
                  PH_LH: phase_ff <= PH_HL;
                  default: begin
                     phase_ff <= PH_LL;
                     // pick the next operation
                     unique case (op_ff)
                        OP_BASE: begin
                           op_ff    <= OP_SEED;
                           idx_ff   <= 3'd0;
                           state_ff <= ST_LOAD;
                        end
                        OP_SEED: begin
                           if (idx_ff != LANE_LAST) begin
                              idx_ff   <= idx_ff + 3'd1;
                              state_ff <= ST_LOAD;
                           end else if (fin_ff) begin
                              op_ff    <= OP_REDUCE;
                              idx_ff   <= 3'd0;
                              state_ff <= ST_LOAD;
                           end else begin
                              state_ff <= ST_IDLE;
                           end
                        end
                        OP_ABSORB: begin
                           if (fin_ff) begin
                              op_ff    <= OP_REDUCE;
                              idx_ff   <= 3'd0;
                              state_ff <= ST_LOAD;
                           end else begin
                              state_ff <= ST_IDLE;
                           end
                        end
                        OP_REDUCE: begin
                           state_ff <= ST_LOAD;
                           if (idx_ff != RED_LAST) begin
                              idx_ff <= idx_ff + 3'd1;
                           end else begin
                              op_ff  <= OP_FINAL;
                              idx_ff <= 3'd0;
                           end
                        end
                        OP_FINAL: begin
                           if (idx_ff != FIN_LAST) begin
                              idx_ff   <= idx_ff + 3'd1;
                              state_ff <= ST_LOAD;
                           end else begin
                              state_ff <= ST_EMIT;
                           end
                        end
                        default: state_ff <= ST_IDLE;
                     endcase
                  end
               endcase
            end
            ST_EMIT: begin
               if (stat.rsp_free) begin
                  fin_ff   <= 1'b0;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

// File: hdl/elmxh_dpath.sv
// ---------------------------------------------------------------------------
// elmxh_dpath
// Lane accumulators, word counter, operand selection, shared 64-bit
// multiplier (three 32x32 passes) and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module elmxh_dpath #(
   parameter int LENGTH_BITS = elmxh_pkg::LENGTH_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire elmxh_pkg::dp_cmd_type               cmd,
   output elmxh_pkg::dp_stat_type                   stat,
   input  wire logic [elmxh_pkg::MSG_LENGTH_W-1:0]  req_msg_length,
   input  wire logic [63:0]                         req_seed,
   input  wire logic [63:0]                         req_data_word,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [elmxh_pkg::RSP_TDATA_W-1:0]        rsp_tdata
);
   import elmxh_pkg::*;

   // length bits kept, and a word counter that can hold the word total
   localparam int LEN_W = (LENGTH_BITS < MSG_LENGTH_W) ? LENGTH_BITS : MSG_LENGTH_W;
   localparam int CNT_W = LEN_W - 2;

   logic [LEN_W-1:0] len_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [63:0]      seed_ff;
   logic [63:0]      base_ff;
   logic [63:0]      h_ff;
   logic [63:0]      lane_ff [LANES];
   logic [63:0]      a_ff;
   logic [63:0]      b_ff;
   logic [63:0]      acc_ff;
   logic [2:0]       sel_ff;
   logic [63:0]      rsp_data_ff;
   logic             rsp_valid_ff;

   logic [LEN_W-1:0] len_in;
   logic [CNT_W-1:0] total_words;
   logic [CNT_W-1:0] cnt_in;
   logic             in_block;
   logic             in_full;
   logic [2:0]       sel;
   logic [63:0]      word_m;
   logic [63:0]      absorb_a;
   logic [63:0]      load_a;
   logic [63:0]      load_b;
   logic [31:0]      mul_x;
   logic [31:0]      mul_y;
   logic [63:0]      prod;
   logic [63:0]      mul_res;
   logic             lane_we;
   logic [2:0]       lane_wa;

   // message position
   assign len_in      = req_msg_length[LEN_W-1:0];
   assign in_block    = cnt_ff[CNT_W-1:3] < {1'b0, len_ff[LEN_W-1:6]};
   assign in_full     = cnt_ff < {1'b0, len_ff[LEN_W-1:3]};
   assign total_words = {1'b0, len_ff[LEN_W-1:3]} + CNT_W'(|len_ff[2:0]);
   assign cnt_in      = cnt_ff + CNT_W'(1);
   assign sel         = in_block ? cnt_ff[2:0] : 3'd0;

   assign stat.len_zero  = (len_in == '0);
   assign stat.last_word = (cnt_in >= total_words);
   assign stat.rsp_free  = !rsp_valid_ff || rsp_tready;

   // tail bytes past the length are dropped
   always_comb begin
      for (int b = 0; b < 8; b++) begin
         word_m[8*b +: 8] = (in_full || (3'(b) < len_ff[2:0])) ?
                            req_data_word[8*b +: 8] : 8'h00;
      end
   end

   assign absorb_a = lane_ff[sel] ^ rotl64(word_m, lane_rot(sel));

   // operands for sequenced operations
   always_comb begin
      load_a = a_ff;
      load_b = b_ff;
      unique case (cmd.op)
         OP_SEED: begin
            load_a = base_ff;
            load_b = seed_mul(cmd.idx);
         end
         OP_REDUCE: begin
            load_b = PHI;
            unique case (cmd.idx)
               3'd0: load_a = lane_ff[0] ^ lane_ff[1];
               3'd1: load_a = lane_ff[2] ^ lane_ff[3];
               3'd2: load_a = lane_ff[4] ^ lane_ff[5];
               3'd3: load_a = lane_ff[6] ^ lane_ff[7];
               3'd4: load_a = lane_ff[0] ^ lane_ff[2];
               3'd5: load_a = lane_ff[4] ^ lane_ff[6];
               default: load_a = lane_ff[0] ^ lane_ff[4];
            endcase
         end
         OP_FINAL: begin
            load_a = h_ff ^ (h_ff >> fin_shift(cmd.idx));
            load_b = fin_mul(cmd.idx);
         end
         default: begin
            load_a = a_ff;
            load_b = b_ff;
         end
      endcase
   end

   // one 32x32 multiplier, low 64 bits of a*b over three passes
   always_comb begin
      unique case (cmd.phase)
         PH_LL: begin
            mul_x = a_ff[31:0];
            mul_y = b_ff[31:0];
         end
         PH_LH: begin
            mul_x = a_ff[31:0];
            mul_y = b_ff[63:32];
         end
         default: begin
            mul_x = a_ff[63:32];
            mul_y = b_ff[31:0];
         end
      endcase
   end

   assign prod    = {32'd0, mul_x} * {32'd0, mul_y};
   assign mul_res = {acc_ff[63:32] + prod[31:0], acc_ff[31:0]};

   // lane write port, used on the last pass
   always_comb begin
      lane_we = cmd.mul_en && (cmd.phase == PH_HL);
      lane_wa = cmd.idx;
      unique case (cmd.op)
         OP_SEED:   lane_wa = cmd.idx;
         OP_ABSORB: lane_wa = sel_ff;
         OP_REDUCE: begin
            lane_wa = red_dest(cmd.idx);
            if (cmd.idx == RED_LAST) begin
               lane_we = 1'b0;
            end
         end
         default:   lane_we = 1'b0;
      endcase
   end

   // operand, accumulator and message registers
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         seed_ff <= req_seed;
         len_ff  <= len_in;
         cnt_ff  <= '0;
         a_ff    <= 64'(len_in);
         b_ff    <= PHI;
      end else if (cmd.absorb) begin
         a_ff   <= absorb_a;
         b_ff   <= PHI;
         sel_ff <= sel;
         cnt_ff <= cnt_in;
      end else if (cmd.load) begin
         a_ff <= load_a;
         b_ff <= load_b;
      end

      if (cmd.mul_en) begin
         unique case (cmd.phase)
            PH_LL: acc_ff <= prod;
            PH_LH: acc_ff[63:32] <= acc_ff[63:32] + prod[31:0];
            default: begin
               if (cmd.op == OP_BASE) begin
                  base_ff <= seed_ff ^ mul_res;
               end
               if ((cmd.op == OP_FINAL) ||
                   ((cmd.op == OP_REDUCE) && (cmd.idx == RED_LAST))) begin
                  h_ff <= mul_res;
               end
            end
         endcase
      end

      if (lane_we) begin
         lane_ff[lane_wa] <= mul_res;
      end

      if (cmd.emit) begin
         rsp_data_ff <= h_ff ^ (h_ff >> 41);
      end
   end

   // result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// File: hdl/eight_lane_multiply_xor_hash_unit.sv
// Data item: operands load at accept, then three passes of the shared 32x32 multiplier.
// Start item: a base multiply and eight lane seeds, each a load plus three passes.
// Finishing adds ten reduce/finalize multiplies and a result load, which waits for
// a free output register; req_tready stays low until the unit is idle again.
// Reset: synchronous, active high; clears the sequencer, open flag and result valid.
`include "assert_macros.svh"
`default_nettype none
// ---------------------------------------------------------------------------
// eight_lane_multiply_xor_hash_unit
// Streaming eight-lane multiply-xor hash over a byte message.
// ---------------------------------------------------------------------------

module eight_lane_multiply_xor_hash_unit #(
   parameter int LENGTH_BITS = elmxh_pkg::LENGTH_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // msg_length[31:0], seed[95:32], data_word[159:96]
   input  wire logic [elmxh_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // cmd[0]
   input  wire logic                               req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // hash_value[63:0]
   output logic [elmxh_pkg::RSP_TDATA_W-1:0]       rsp_tdata
);
   import elmxh_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   elmxh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_cmd    (req_tuser),
      .stat       (stat),
      .cmd        (cmd)
   );

   elmxh_dpath #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_msg_length (req_tdata[31:0]),
      .req_seed       (req_tdata[95:32]),
      .req_data_word  (req_tdata[159:96]),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata)
   );

   // busy while the multiplier runs
   `ASSERT_IMPL(a_busy_mul, clock, reset, cmd.mul_en, !req_tready)
   // a result is only loaded into a free output register
   `ASSERT_IMPL(a_emit_free, clock, reset, cmd.emit, !rsp_tvalid || rsp_tready)
   // a start always runs the seeding sequence
   `ASSERT_NEXT(a_start_busy, clock, reset,
                req_tvalid && req_tready && (req_tuser == CMD_START), !req_tready)

endmodule

`default_nettype wire
